/* hdl/ymrf_pkg.sv */
package ymrf_pkg;

	localparam int LONG_BLOCK_BYTES = 1024;
	localparam int SHORT_BLOCK_BYTES = 128;
	localparam int RES_MAX = 4;

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_REQ = 8'h43;
	localparam logic [7:0] B_SPACE = 8'h20;

	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_NAME = 3'd1;
	localparam logic [2:0] KIND_REPLY = 3'd2;
	localparam logic [2:0] KIND_VERDICT = 3'd3;
	localparam logic [2:0] KIND_EVENT = 3'd4;

	localparam logic [2:0] VERD_OK = 3'd0;
	localparam logic [2:0] VERD_REPEAT = 3'd1;
	localparam logic [2:0] VERD_LOST = 3'd2;
	localparam logic [2:0] VERD_CRC = 3'd3;
	localparam logic [2:0] VERD_BAD_START = 3'd4;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_FILE_DONE = 3'd1;
	localparam logic [2:0] EV_ALL_DONE = 3'd2;
	localparam logic [2:0] EV_CANCELLED = 3'd3;
	localparam logic [2:0] EV_ABORTED = 3'd4;

	localparam logic [1:0] HDR_NAME = 2'd0;
	localparam logic [1:0] HDR_LENGTH = 2'd1;
	localparam logic [1:0] HDR_DONE = 2'd2;

	typedef struct packed {
		logic        in_packet;
		logic        long_block;
		logic [10:0] byte_pos;
		logic [7:0]  exp_blk;
		logic [7:0]  rcv_blk;
		logic [15:0] crc;
		logic        awaiting_header;
		logic [1:0]  header_phase;
		logic        name_nonempty;
		logic [31:0] parsed_len;
		logic [31:0] remaining_len;
		logic [1:0]  cancel_cnt;
		logic        stopped;
	} st_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic        keep;
		logic [2:0]  verdict;
		logic [2:0]  session_event;
		logic [31:0] file_length;
		logic        last;
	} res_t;

	localparam st_t ST_RESET = '{awaiting_header: 1'b1, header_phase: HDR_NAME, default: '0};

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
		end
		return v;
	endfunction

	function automatic res_t mk(input logic [2:0] kind, input logic [7:0] value,
		input logic keep, input logic [2:0] verdict, input logic [2:0] ev,
		input logic [31:0] len);
		res_t r;
		r.kind = kind;
		r.value = value;
		r.keep = keep;
		r.verdict = verdict;
		r.session_event = ev;
		r.file_length = len;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

/* hdl/ymrf_step.sv */
module ymrf_step (
	input  ymrf_pkg::st_t                      st,
	input  logic [7:0]                         b,
	output ymrf_pkg::st_t                      nx,
	output ymrf_pkg::res_t [ymrf_pkg::RES_MAX-1:0] res,
	output logic [2:0]                         n
);
	import ymrf_pkg::*;

	logic [10:0] blk;
	logic [10:0] p;
	logic [10:0] off;
	logic [7:0]  rb;
	logic        match;
	logic [15:0] crc_n;
	logic [35:0] mul;
	logic [1:0]  cc;

	always_comb begin
		nx = st;
		n = 3'd0;
		res = '0;
		blk = st.long_block ? 11'(LONG_BLOCK_BYTES) : 11'(SHORT_BLOCK_BYTES);
		p = st.byte_pos;
		off = p - 11'd3;
		rb = (p == 11'd1) ? b : st.rcv_blk;
		match = (rb == st.exp_blk);
		crc_n = (p >= 11'd3) ? crc_byte(st.crc, b) : st.crc;
		mul = {1'b0, st.parsed_len, 3'b000} + {3'b000, st.parsed_len, 1'b0} + {32'd0, b[3:0]};
		cc = st.cancel_cnt + 2'd1;
		if (!st.stopped) begin
			if (!st.in_packet) begin
				if (b == B_SOH || b == B_STX) begin
					nx.cancel_cnt = 2'd0;
					nx.in_packet = 1'b1;
					nx.long_block = (b == B_STX);
					nx.byte_pos = 11'd1;
					nx.crc = '0;
					nx.rcv_blk = '0;
					nx.header_phase = HDR_NAME;
					nx.name_nonempty = 1'b0;
					nx.parsed_len = '0;
				end else if (b == B_EOT) begin
					nx.cancel_cnt = 2'd0;
					res[0] = mk(KIND_REPLY, B_ACK, 1'b0, VERD_OK, EV_NONE, '0);
					res[1] = mk(KIND_REPLY, B_REQ, 1'b0, VERD_OK, EV_NONE, '0);
					res[2] = mk(KIND_EVENT, '0, 1'b0, VERD_OK, EV_FILE_DONE, '0);
					n = 3'd3;
					nx.exp_blk = '0;
					nx.awaiting_header = 1'b1;
					nx.remaining_len = '0;
				end else if (b == B_CAN) begin
					nx.cancel_cnt = cc;
					if (cc >= 2'd2) begin
						res[0] = mk(KIND_EVENT, '0, 1'b0, VERD_OK, EV_CANCELLED, '0);
						n = 3'd1;
						nx.stopped = 1'b1;
					end
				end else begin
					nx.cancel_cnt = 2'd0;
					res[0] = mk(KIND_VERDICT, '0, 1'b0, VERD_BAD_START, EV_NONE, '0);
					res[1] = mk(KIND_REPLY, B_NAK, 1'b0, VERD_OK, EV_NONE, '0);
					n = 3'd2;
				end
			end else begin
				nx.rcv_blk = rb;
				nx.crc = crc_n;
				if (p >= 11'd3 && p < blk + 11'd3 && match) begin
					if (st.awaiting_header && rb == 8'd0) begin
						if (st.header_phase == HDR_NAME) begin
							if (b == 8'd0) begin
								nx.header_phase = HDR_LENGTH;
							end else begin
								res[0] = mk(KIND_NAME, b, 1'b0, VERD_OK, EV_NONE, '0);
								n = 3'd1;
								nx.name_nonempty = 1'b1;
							end
						end else if (st.header_phase == HDR_LENGTH) begin
							if (b == B_SPACE || b == 8'd0) begin
								nx.header_phase = HDR_DONE;
							end else begin
								nx.parsed_len = (mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : mul[31:0];
							end
						end
					end else begin
						res[0] = mk(KIND_PAYLOAD, b,
							(st.remaining_len == 32'd0) || ({21'd0, off} < st.remaining_len),
							VERD_OK, EV_NONE, '0);
						n = 3'd1;
					end
				end
				nx.byte_pos = p + 11'd1;
				if (p >= blk + 11'd4) begin
					nx.in_packet = 1'b0;
					nx.byte_pos = '0;
					if (!match) begin
						if (rb == st.exp_blk - 8'd1) begin
							res[0] = mk(KIND_VERDICT, '0, 1'b0, VERD_REPEAT, EV_NONE, '0);
							res[1] = mk(KIND_REPLY, B_ACK, 1'b0, VERD_OK, EV_NONE, '0);
							n = 3'd2;
						end else begin
							res[0] = mk(KIND_VERDICT, '0, 1'b0, VERD_LOST, EV_NONE, '0);
							if (st.awaiting_header) begin
								res[1] = mk(KIND_REPLY, B_NAK, 1'b0, VERD_OK, EV_NONE, '0);
								n = 3'd2;
							end else begin
								res[1] = mk(KIND_REPLY, B_CAN, 1'b0, VERD_OK, EV_NONE, '0);
								res[2] = mk(KIND_REPLY, B_CAN, 1'b0, VERD_OK, EV_NONE, '0);
								res[3] = mk(KIND_EVENT, '0, 1'b0, VERD_OK, EV_ABORTED, '0);
								n = 3'd4;
								nx.stopped = 1'b1;
							end
						end
					end else if (crc_n != 16'd0) begin
						res[0] = mk(KIND_VERDICT, '0, 1'b0, VERD_CRC, EV_NONE, '0);
						res[1] = mk(KIND_REPLY, B_NAK, 1'b0, VERD_OK, EV_NONE, '0);
						n = 3'd2;
					end else begin
						nx.exp_blk = rb + 8'd1;
						if (st.awaiting_header && rb == 8'd0) begin
							if (!st.name_nonempty) begin
								res[0] = mk(KIND_VERDICT, '0, 1'b0, VERD_OK, EV_NONE, '0);
								res[1] = mk(KIND_REPLY, B_ACK, 1'b0, VERD_OK, EV_NONE, '0);
								res[2] = mk(KIND_EVENT, '0, 1'b0, VERD_OK, EV_ALL_DONE, '0);
								n = 3'd3;
								nx.stopped = 1'b1;
							end else begin
								nx.remaining_len = st.parsed_len;
								res[0] = mk(KIND_VERDICT, '0, 1'b0, VERD_OK, EV_NONE,
									st.parsed_len);
								res[1] = mk(KIND_REPLY, B_ACK, 1'b0, VERD_OK, EV_NONE, '0);
								res[2] = mk(KIND_REPLY, B_REQ, 1'b0, VERD_OK, EV_NONE, '0);
								n = 3'd3;
							end
						end else begin
							nx.awaiting_header = 1'b0;
							nx.remaining_len = (st.remaining_len > {21'd0, blk}) ?
								st.remaining_len - {21'd0, blk} : 32'd0;
							res[0] = mk(KIND_VERDICT, '0, 1'b0, VERD_OK, EV_NONE, '0);
							res[1] = mk(KIND_REPLY, B_ACK, 1'b0, VERD_OK, EV_NONE, '0);
							n = 3'd2;
						end
					end
				end
			end
		end
		for (int i = 0; i < RES_MAX; i++) begin
			res[i].last = (3'(i + 1) == n);
		end
	end

endmodule

/* hdl/ymrf_outq.sv */
module ymrf_outq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  ymrf_pkg::res_t [ymrf_pkg::RES_MAX-1:0] res,
	input  logic [2:0]                         n,
	input  logic                               take,
	output ymrf_pkg::res_t                     head,
	output logic                               valid,
	output logic                               can_load
);
	import ymrf_pkg::*;

	res_t [RES_MAX-1:0] buf_q;
	logic [2:0]         cnt_q;
	logic [1:0]         rd_q;

	assign valid = (cnt_q != 3'd0);
	assign head = buf_q[rd_q];
	// The last pending result may leave in the same cycle that a new burst lands.
	assign can_load = (cnt_q == 3'd0) || (cnt_q == 3'd1 && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
		end else if (load) begin
			cnt_q <= n;
			rd_q <= '0;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res;
		end
	end

	always_comb begin
		if (cnt_q > 3'd4) begin
			$error("result count out of range");
		end
	end

endmodule

/* hdl/ymodem_receive_framer_core.sv */
// A byte is registered on acceptance; its results are loaded into the result buffer when
// it can take them. Throughput: one byte per cycle while a byte yields at most one result
// and out_stall is low; a byte with more results holds the input register while they drain.
// Reset (arst_n low, asynchronous) clears the framer state, the input register and the
// result buffer; a header block is awaited afterwards.
module ymodem_receive_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  value,
	output logic        keep,
	output logic [2:0]  verdict,
	output logic [2:0]  session_event,
	output logic [31:0] file_length,
	output logic        last
);
	import ymrf_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	st_t                st_q;
	st_t                st_nx;
	res_t [RES_MAX-1:0] res;
	logic [2:0]         n;
	res_t               head;
	logic               take;
	logic               can_load;
	logic               adv;

	assign take = out_valid && !out_stall;
	assign adv = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= ST_RESET;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				st_q <= st_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	ymrf_step u_step (
		.st  (st_q),
		.b   (byte_s1),
		.nx  (st_nx),
		.res (res),
		.n   (n)
	);

	ymrf_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.n        (n),
		.take     (take),
		.head     (head),
		.valid    (out_valid),
		.can_load (can_load)
	);

	assign kind = head.kind;
	assign value = head.value;
	assign keep = head.keep;
	assign verdict = head.verdict;
	assign session_event = head.session_event;
	assign file_length = head.file_length;
	assign last = head.last;

	// Once stopped, a byte changes no state and produces nothing.
	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && st_q.stopped) |=> !out_valid && st_q.stopped)
		else $error("stopped framer produced a result");

	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled without pending work");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last && !adv) |=> !out_valid)
		else $error("results remain after the final one");

	a_packet_pos: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.in_packet |-> st_q.byte_pos != 11'd0)
		else $error("packet open at position zero");

endmodule

/* verif/ymrf_checker.sv */
package ymrf_tb_pkg;

	// CRC-16/XMODEM update for one byte, MSB first.
	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (v[15])
				v = (v << 1) ^ 16'h1021;
			else
				v = v << 1;
		end
		return v;
	endfunction

endpackage

module ymrf_checker
	import ymrf_pkg::*;
	import ymrf_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  value,
	input  logic        keep,
	input  logic [2:0]  verdict,
	input  logic [2:0]  session_event,
	input  logic [31:0] file_length,
	input  logic        last,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	res_t expected_q[$];

	logic        fr_in_pkt;
	logic        fr_long;
	int          fr_pos;
	logic [7:0]  fr_exp_blk;
	logic [7:0]  fr_rcv_blk;
	logic [15:0] fr_crc;
	logic        fr_want_hdr;
	logic [1:0]  fr_phase;
	logic        fr_named;
	logic [31:0] fr_plen;
	logic [31:0] fr_remain;
	logic [1:0]  fr_can_cnt;
	logic        fr_halted;
	int          fr_emitted;
	int          fail_cnt = 0;

	assign fails = fail_cnt;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
		fail_cnt++;
	endtask

	function automatic void emit(input logic [2:0] k, input logic [7:0] v, input logic kp,
		input logic [2:0] vd, input logic [2:0] ev, input logic [31:0] len);
		res_t r;
		r.kind = k;
		r.value = v;
		r.keep = kp;
		r.verdict = vd;
		r.session_event = ev;
		r.file_length = len;
		r.last = 1'b0;
		expected_q.push_back(r);
		fr_emitted++;
	endfunction

	function automatic void frame_byte(input logic [7:0] b);
		int blk;
		logic match;
		logic [63:0] acc;
		fr_emitted = 0;
		if (fr_halted)
			return;
		if (!fr_in_pkt) begin
			if (b == B_SOH || b == B_STX) begin
				fr_can_cnt = 0;
				fr_in_pkt = 1'b1;
				fr_long = (b == B_STX);
				fr_pos = 1;
				fr_crc = '0;
				fr_rcv_blk = '0;
				fr_phase = HDR_NAME;
				fr_named = 1'b0;
				fr_plen = '0;
			end else if (b == B_EOT) begin
				fr_can_cnt = 0;
				emit(KIND_REPLY, B_ACK, 0, VERD_OK, EV_NONE, 0);
				emit(KIND_REPLY, B_REQ, 0, VERD_OK, EV_NONE, 0);
				emit(KIND_EVENT, 0, 0, VERD_OK, EV_FILE_DONE, 0);
				fr_exp_blk = '0;
				fr_want_hdr = 1'b1;
				fr_remain = '0;
			end else if (b == B_CAN) begin
				fr_can_cnt = fr_can_cnt + 2'd1;
				if (fr_can_cnt >= 2) begin
					emit(KIND_EVENT, 0, 0, VERD_OK, EV_CANCELLED, 0);
					fr_halted = 1'b1;
				end
			end else begin
				fr_can_cnt = 0;
				emit(KIND_VERDICT, 0, 0, VERD_BAD_START, EV_NONE, 0);
				emit(KIND_REPLY, B_NAK, 0, VERD_OK, EV_NONE, 0);
			end
		end else begin
			blk = fr_long ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
			if (fr_pos == 1)
				fr_rcv_blk = b;
			match = (fr_rcv_blk == fr_exp_blk);
			if (fr_pos >= 3) begin
				fr_crc = crc16_next(fr_crc, b);
				if (fr_pos < 3 + blk && match) begin
					if (fr_want_hdr && fr_rcv_blk == 0) begin
						if (fr_phase == HDR_NAME) begin
							if (b == 0) begin
								fr_phase = HDR_LENGTH;
							end else begin
								emit(KIND_NAME, b, 0, VERD_OK, EV_NONE, 0);
								fr_named = 1'b1;
							end
						end else if (fr_phase == HDR_LENGTH) begin
							if (b == B_SPACE || b == 0) begin
								fr_phase = HDR_DONE;
							end else begin
								acc = 64'(fr_plen) * 10 + 64'(b & 8'h0f);
								fr_plen = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
							end
						end
					end else begin
						emit(KIND_PAYLOAD, b,
							(fr_remain == 0 || 32'(fr_pos - 3) < fr_remain),
							VERD_OK, EV_NONE, 0);
					end
				end
			end
			if (fr_pos >= blk + 4) begin
				fr_in_pkt = 1'b0;
				fr_pos = 0;
				if (!match) begin
					if (fr_rcv_blk == fr_exp_blk - 8'd1) begin
						emit(KIND_VERDICT, 0, 0, VERD_REPEAT, EV_NONE, 0);
						emit(KIND_REPLY, B_ACK, 0, VERD_OK, EV_NONE, 0);
					end else begin
						emit(KIND_VERDICT, 0, 0, VERD_LOST, EV_NONE, 0);
						if (fr_want_hdr) begin
							emit(KIND_REPLY, B_NAK, 0, VERD_OK, EV_NONE, 0);
						end else begin
							emit(KIND_REPLY, B_CAN, 0, VERD_OK, EV_NONE, 0);
							emit(KIND_REPLY, B_CAN, 0, VERD_OK, EV_NONE, 0);
							emit(KIND_EVENT, 0, 0, VERD_OK, EV_ABORTED, 0);
							fr_halted = 1'b1;
						end
					end
				end else if (fr_crc != 0) begin
					emit(KIND_VERDICT, 0, 0, VERD_CRC, EV_NONE, 0);
					emit(KIND_REPLY, B_NAK, 0, VERD_OK, EV_NONE, 0);
				end else begin
					fr_exp_blk = fr_rcv_blk + 8'd1;
					if (fr_want_hdr && fr_rcv_blk == 0) begin
						if (!fr_named) begin
							emit(KIND_VERDICT, 0, 0, VERD_OK, EV_NONE, 0);
							emit(KIND_REPLY, B_ACK, 0, VERD_OK, EV_NONE, 0);
							emit(KIND_EVENT, 0, 0, VERD_OK, EV_ALL_DONE, 0);
							fr_halted = 1'b1;
						end else begin
							fr_remain = fr_plen;
							emit(KIND_VERDICT, 0, 0, VERD_OK, EV_NONE, fr_plen);
							emit(KIND_REPLY, B_ACK, 0, VERD_OK, EV_NONE, 0);
							emit(KIND_REPLY, B_REQ, 0, VERD_OK, EV_NONE, 0);
						end
					end else begin
						fr_want_hdr = 1'b0;
						fr_remain = (fr_remain > blk) ? fr_remain - blk : 32'd0;
						emit(KIND_VERDICT, 0, 0, VERD_OK, EV_NONE, 0);
						emit(KIND_REPLY, B_ACK, 0, VERD_OK, EV_NONE, 0);
					end
				end
			end else begin
				fr_pos = fr_pos + 1;
			end
		end
		if (fr_emitted > 0)
			expected_q[$].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			fr_in_pkt = 1'b0;
			fr_long = 1'b0;
			fr_pos = 0;
			fr_exp_blk = '0;
			fr_rcv_blk = '0;
			fr_crc = '0;
			fr_want_hdr = 1'b1;
			fr_phase = HDR_NAME;
			fr_named = 1'b0;
			fr_plen = '0;
			fr_remain = '0;
			fr_can_cnt = '0;
			fr_halted = 1'b0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected result kind", kind, 0);
				end else begin
					res_t e;
					e = expected_q.pop_front();
					if (kind !== e.kind) report("kind", kind, e.kind);
					if (value !== e.value) report("value", value, e.value);
					if (keep !== e.keep) report("keep", keep, e.keep);
					if (verdict !== e.verdict) report("verdict", verdict, e.verdict);
					if (session_event !== e.session_event)
						report("session_event", session_event, e.session_event);
					if (file_length !== e.file_length)
						report("file_length", file_length, e.file_length);
					if (last !== e.last) report("last", last, e.last);
				end
			end
			if (in_valid && !in_stall)
				frame_byte(rx_byte);
			pending <= expected_q.size();
		end
	end

endmodule

/* verif/tb.sv */
module tb;
	import ymrf_pkg::*;
	import ymrf_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [7:0]  value;
	logic        keep;
	logic [2:0]  verdict;
	logic [2:0]  session_event;
	logic [31:0] file_length;
	logic        last;
	int          fails;
	int          pending;
	int          idle_cycles = 0;
	bit          calm;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	logic [7:0]  block_bytes[$];

	ymodem_receive_framer_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .value(value), .keep(keep), .verdict(verdict),
		.session_event(session_event), .file_length(file_length), .last(last)
	);

	ymrf_checker i_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .value(value), .keep(keep), .verdict(verdict),
		.session_event(session_event), .file_length(file_length), .last(last),
		.fails(fails), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(input logic [7:0] b);
		int gap;
		logic st;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
	endtask

	// Pads the staged data with zeros to the block size and sends a full packet.
	task automatic send_block(input bit is_long, input logic [7:0] blk, input bit bad_crc);
		int size;
		logic [15:0] c;
		size = is_long ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
		while (block_bytes.size() < size)
			block_bytes.push_back(8'h00);
		send(is_long ? B_STX : B_SOH);
		send(blk);
		send(~blk);
		c = '0;
		foreach (block_bytes[i]) begin
			c = crc16_next(c, block_bytes[i]);
			send(block_bytes[i]);
		end
		if (bad_crc)
			c = c ^ (16'h0001 << $urandom_range(0, 15));
		send(c[15:8]);
		send(c[7:0]);
		block_bytes.delete();
	endtask

	task automatic stage_header(input int name_bytes, input string len_text, input bit space_end);
		for (int i = 0; i < name_bytes; i++)
			block_bytes.push_back(8'($urandom_range(1, 255)));
		block_bytes.push_back(8'h00);
		for (int i = 0; i < len_text.len(); i++)
			block_bytes.push_back(len_text[i]);
		block_bytes.push_back(space_end ? B_SPACE : 8'h00);
	endtask

	task automatic stage_data(input int n);
		for (int i = 0; i < n; i++)
			block_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic send_data(input bit is_long, input logic [7:0] blk, input bit bad_crc);
		stage_data(is_long ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES);
		send_block(is_long, blk, bad_crc);
	endtask

	// A bad start byte, never a control code that would open a packet or cancel.
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == B_SOH || b == B_STX || b == B_EOT || b == B_CAN);
		return b;
	endfunction

	initial begin
		int gap;
		bit v;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				v = out_valid;
				@(posedge clk);
			end while (!v);
		end
	end

	initial begin
		int file_len;
		int left;
		int longs;
		int pick;
		logic [7:0] blk;
		bit is_long;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bad starts, a lone CAN cleared by another byte, the repeat of
		// block 255 after reset, a lost block while a header is awaited.
		send(8'h00);
		send(8'hFF);
		send(B_CAN);
		send(8'h55);
		send(B_CAN);
		send_data(1'b0, 8'hFF, 1'b0);
		send_data(1'b0, 8'd3, 1'b0);
		// Header with a CRC error, then resent with a saturating length.
		stage_header(5, "99999999999", 1'b1);
		send_block(1'b0, 8'd0, 1'b1);
		stage_header(5, "99999999999", 1'b1);
		send_block(1'b0, 8'd0, 1'b0);
		send(B_EOT);
		// A name that fills the whole block leaves the length unknown.
		stage_data(0);
		for (int i = 0; i < SHORT_BLOCK_BYTES; i++)
			block_bytes.push_back(8'($urandom_range(1, 255)));
		send_block(1'b0, 8'd0, 1'b0);
		send_data(1'b0, 8'd1, 1'b0);
		send_data(1'b0, 8'd1, 1'b0);
		send_data(1'b0, 8'd2, 1'b1);
		send_data(1'b1, 8'd2, 1'b0);
		send(B_EOT);
		// A length with a non-digit character, ended by a zero byte.
		stage_header(3, "1x0", 1'b0);
		send_block(1'b0, 8'd0, 1'b0);
		send_data(1'b0, 8'd1, 1'b0);
		send(B_EOT);

		// Random files; the receiver holds off once during the first one.
		longs = 0;
		for (int f = 0; f < 6; f++) begin
			calm = ($urandom_range(0, 3) == 0);
			if (f == 0)
				hold_req = 1'b1;
			if ($urandom_range(0, 4) == 0)
				file_len = $urandom_range(0, 3000);
			else
				file_len = $urandom_range(0, 500);
			stage_header($urandom_range(1, 12), $sformatf("%0d", file_len),
				$urandom_range(0, 1));
			if ($urandom_range(0, 5) == 0)
				send_block(1'b0, 8'd0, 1'b1);
			else if ($urandom_range(0, 5) == 0)
				send(noise_byte());
			// A header lost to a CRC error is staged again before it is resent.
			if (block_bytes.size() == 0)
				stage_header($urandom_range(1, 12), $sformatf("%0d", file_len), 1'b1);
			send_block(1'b0, 8'd0, 1'b0);
			left = file_len;
			blk = 8'd1;
			do begin
				is_long = (longs < 3 && $urandom_range(0, 7) == 0);
				if (is_long)
					longs++;
				pick = $urandom_range(0, 19);
				if (pick < 2) begin
					send_data(is_long, blk, 1'b1);
				end else if (pick < 4) begin
					send(noise_byte());
				end
				send_data(is_long, blk, 1'b0);
				if (pick == 4)
					send_data(1'b0, blk, 1'b0);
				left -= is_long ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
				blk = blk + 8'd1;
			end while (left > 0);
			send(B_EOT);
		end
		calm = 1'b0;

		// One way of ending the session, then bytes that must be ignored.
		pick = $urandom_range(0, 2);
		if (pick == 0) begin
			send_block(1'b0, 8'd0, 1'b0);
		end else if (pick == 1) begin
			send(B_CAN);
			send(B_CAN);
		end else begin
			stage_header(4, "200", 1'b1);
			send_block(1'b0, 8'd0, 1'b0);
			send_data(1'b0, 8'd1, 1'b0);
			send_data(1'b0, 8'd9, 1'b0);
		end
		send(B_EOT);
		send(B_SOH);
		send(8'h33);
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* ymodem_receive_framer_core.f */
hdl/ymrf_pkg.sv
hdl/ymrf_step.sv
hdl/ymrf_outq.sv
hdl/ymodem_receive_framer_core.sv
verif/ymrf_checker.sv
verif/tb.sv
